// ----- rtl/rrc_pkg.sv -----
package rrc_pkg;

   // Fixed widths of the stream fields.
   localparam int FIELD_WIDTH = 64;
   localparam int DEFAULT_VALUE_WIDTH = 64;

   // Request: num_a, den_a, num_b, den_b from bit 0 up.
   localparam int REQ_DATA_WIDTH = 4 * FIELD_WIDTH;

   // Response: num_out, den_out, equal, then zero fill up to a whole byte.
   localparam int RSP_EQUAL_BIT = 2 * FIELD_WIDTH;
   localparam int RSP_DATA_WIDTH = ((2 * FIELD_WIDTH + 1 + 7) / 8) * 8;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RED_A,
      ST_RED_B,
      ST_HOLD
   } rrc_state_type;

   typedef enum logic [2:0] {
      FR_IDLE,
      FR_GCD,
      FR_DIV_NUM,
      FR_DIV_DEN,
      FR_DONE
   } rrc_frac_state_type;

   // Handshake between the top level and the fraction reducer.
   typedef struct packed {
      logic start;
   } rrc_frac_ctl_type;

   typedef struct packed {
      logic done;
   } rrc_frac_status_type;

endpackage

// ----- rtl/rrc_frac.sv -----
module rrc_frac #(
   parameter int VALUE_WIDTH = rrc_pkg::DEFAULT_VALUE_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  rrc_pkg::rrc_frac_ctl_type       ctl,
   input  logic signed [VALUE_WIDTH-1:0]   frac_num,
   input  logic signed [VALUE_WIDTH-1:0]   frac_den,
   output rrc_pkg::rrc_frac_status_type    status,
   output logic signed [VALUE_WIDTH-1:0]   res_num,
   output logic signed [VALUE_WIDTH-1:0]   res_den
);

   localparam int KW = $clog2(VALUE_WIDTH);
   localparam int CW = $clog2(VALUE_WIDTH + 1);

   rrc_pkg::rrc_frac_state_type state_ff, state_in;

   logic signed [VALUE_WIDTH-1:0] num_ff, num_in;
   logic signed [VALUE_WIDTH-1:0] den_ff, den_in;
   logic [VALUE_WIDTH-1:0] a_ff, a_in;
   logic [VALUE_WIDTH-1:0] b_ff, b_in;
   logic [KW-1:0]          k_ff, k_in;
   logic [VALUE_WIDTH-1:0] g_ff, g_in;
   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic [VALUE_WIDTH-1:0] dvd_ff, dvd_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic signed [VALUE_WIDTH-1:0] res_num_ff, res_num_in;
   logic signed [VALUE_WIDTH-1:0] res_den_ff, res_den_in;

   logic [VALUE_WIDTH:0]   sub_x;
   logic [VALUE_WIDTH:0]   sub_y;
   logic [VALUE_WIDTH+1:0] diff;
   logic                   borrow;
   logic                   gcd_end;
   logic                   div_last;
   logic [VALUE_WIDTH-1:0] quot;

   // The most negative value maps to 2^(W-1), which still fits unsigned.
   function automatic logic [VALUE_WIDTH-1:0] mag(input logic [VALUE_WIDTH-1:0] v);
      mag = v[VALUE_WIDTH-1] ? (~v + 1'b1) : v;
   endfunction

   function automatic logic [VALUE_WIDTH-1:0] apply_sign(input logic neg,
                                                         input logic [VALUE_WIDTH-1:0] q);
      apply_sign = neg ? (~q + 1'b1) : q;
   endfunction

   // One subtractor serves both the GCD compare and the division trials.
   always_comb begin
      if (state_ff == rrc_pkg::FR_GCD) begin
         sub_x = {1'b0, a_ff};
         sub_y = {1'b0, b_ff};
      end else begin
         sub_x = {rem_ff, dvd_ff[VALUE_WIDTH-1]};
         sub_y = {1'b0, g_ff};
      end
      diff   = {1'b0, sub_x} - {1'b0, sub_y};
      borrow = diff[VALUE_WIDTH+1];
   end

   assign gcd_end  = (a_ff == '0) || (b_ff == '0);
   assign div_last = (cnt_ff == CW'(1));
   assign quot     = {dvd_ff[VALUE_WIDTH-2:0], ~borrow};

   // A new fraction may start in the done cycle, so the second fraction of a
   // compare request goes from done straight into the GCD, not through idle.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff) inside
         rrc_pkg::FR_IDLE, rrc_pkg::FR_DONE: begin
            state_in = rrc_pkg::FR_IDLE;
            if (ctl.start) begin
               state_in = (frac_den == '0) ? rrc_pkg::FR_DONE : rrc_pkg::FR_GCD;
            end
         end
         rrc_pkg::FR_GCD: begin
            if (gcd_end) begin
               state_in = rrc_pkg::FR_DIV_NUM;
            end
         end
         rrc_pkg::FR_DIV_NUM: begin
            if (div_last) begin
               state_in = rrc_pkg::FR_DIV_DEN;
            end
         end
         rrc_pkg::FR_DIV_DEN: begin
            if (div_last) begin
               state_in = rrc_pkg::FR_DONE;
            end
         end
         default: begin
            state_in = rrc_pkg::FR_IDLE;
         end
      endcase
   end

   always_comb begin
      num_in     = num_ff;
      den_in     = den_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      k_in       = k_ff;
      g_in       = g_ff;
      rem_in     = rem_ff;
      dvd_in     = dvd_ff;
      cnt_in     = cnt_ff;
      res_num_in = res_num_ff;
      res_den_in = res_den_ff;
      unique case (state_ff) inside
         rrc_pkg::FR_IDLE, rrc_pkg::FR_DONE: begin
            if (ctl.start) begin
               num_in     = frac_num;
               den_in     = frac_den;
               a_in       = mag(frac_num);
               b_in       = mag(frac_den);
               k_in       = '0;
               res_num_in = frac_num;
               res_den_in = frac_den;
            end
         end
         rrc_pkg::FR_GCD: begin
            if (gcd_end) begin
               g_in   = (a_ff | b_ff) << k_ff;
               rem_in = '0;
               dvd_in = mag(num_ff);
               cnt_in = CW'(VALUE_WIDTH);
            end else if (!a_ff[0] && !b_ff[0]) begin
               a_in = a_ff >> 1;
               b_in = b_ff >> 1;
               k_in = k_ff + 1'b1;
            end else if (!a_ff[0]) begin
               a_in = a_ff >> 1;
            end else if (!b_ff[0]) begin
               b_in = b_ff >> 1;
            end else if (!borrow) begin
               a_in = diff[VALUE_WIDTH-1:0];
            end else begin
               // Both odd and a below b: swap so the next step subtracts.
               a_in = b_ff;
               b_in = a_ff;
            end
         end
         rrc_pkg::FR_DIV_NUM, rrc_pkg::FR_DIV_DEN: begin
            rem_in = borrow ? sub_x[VALUE_WIDTH-1:0] : diff[VALUE_WIDTH-1:0];
            dvd_in = quot;
            cnt_in = cnt_ff - 1'b1;
            if (div_last) begin
               if (state_ff == rrc_pkg::FR_DIV_NUM) begin
                  res_num_in = apply_sign(num_ff[VALUE_WIDTH-1], quot);
                  rem_in     = '0;
                  dvd_in     = mag(den_ff);
                  cnt_in     = CW'(VALUE_WIDTH);
               end else begin
                  res_den_in = apply_sign(den_ff[VALUE_WIDTH-1], quot);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rrc_pkg::FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
      num_ff     <= num_in;
      den_ff     <= den_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      k_ff       <= k_in;
      g_ff       <= g_in;
      rem_ff     <= rem_in;
      dvd_ff     <= dvd_in;
      cnt_ff     <= cnt_in;
      res_num_ff <= res_num_in;
      res_den_ff <= res_den_in;
   end

   assign status.done = (state_ff == rrc_pkg::FR_DONE);
   assign res_num     = res_num_ff;
   assign res_den     = res_den_ff;

endmodule

// ----- rtl/rational_reduce_compare.sv -----
// Reduces a signed fraction to lowest terms by dividing numerator and
// denominator by the GCD of their magnitudes; each keeps its own sign, so
// 1/2 and -1/-2 compare unequal. A zero denominator passes the fraction
// through unchanged. With req_tuser set, fraction B is reduced too and
// equal reports whether both reduced parts match. Values are VALUE_WIDTH-bit
// two's complement; upper field bits are ignored and results are
// sign-extended to 64 bits. One request takes, per fraction, a setup, a
// binary GCD and two restoring divisions of VALUE_WIDTH steps each, all on
// one shared subtractor; compare mode runs this twice. A zero denominator
// skips the GCD and both divisions.
// req_tready is high only while the reducer is idle; a finished response
// waits in its own register, so the next request may start meanwhile.
module rational_reduce_compare #(
   parameter int VALUE_WIDTH = rrc_pkg::DEFAULT_VALUE_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // num_a [63:0], den_a [127:64], num_b [191:128], den_b [255:192]
   input  logic [rrc_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   // mode [0]
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // num_out [63:0], den_out [127:64], equal [128], zero fill [135:129]
   output logic [rrc_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata
);

   localparam int FW = rrc_pkg::FIELD_WIDTH;

   rrc_pkg::rrc_state_type state_ff, state_in;

   logic                          mode_ff, mode_in;
   logic signed [VALUE_WIDTH-1:0] nb_ff, nb_in;
   logic signed [VALUE_WIDTH-1:0] db_ff, db_in;
   logic signed [VALUE_WIDTH-1:0] an_ff, an_in;
   logic signed [VALUE_WIDTH-1:0] ad_ff, ad_in;
   logic                          eq_ff, eq_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [FW-1:0]          rsp_num_ff, rsp_num_in;
   logic signed [FW-1:0]          rsp_den_ff, rsp_den_in;
   logic                          rsp_eq_ff, rsp_eq_in;

   logic                          accept;
   logic                          load_out;
   rrc_pkg::rrc_frac_ctl_type     frac_ctl;
   rrc_pkg::rrc_frac_status_type  frac_status;
   logic signed [VALUE_WIDTH-1:0] frac_num;
   logic signed [VALUE_WIDTH-1:0] frac_den;
   logic signed [VALUE_WIDTH-1:0] res_num;
   logic signed [VALUE_WIDTH-1:0] res_den;

   assign req_tready = (state_ff == rrc_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign load_out   = (state_ff == rrc_pkg::ST_HOLD) && (!rsp_valid_ff || rsp_tready);

   // Fraction A comes straight off the request; B from its holding registers.
   assign frac_num = (state_ff == rrc_pkg::ST_IDLE) ? req_tdata[VALUE_WIDTH-1:0] : nb_ff;
   assign frac_den = (state_ff == rrc_pkg::ST_IDLE) ? req_tdata[FW+VALUE_WIDTH-1:FW] : db_ff;
   assign frac_ctl.start = accept ||
                           ((state_ff == rrc_pkg::ST_RED_A) && frac_status.done && mode_ff);

   rrc_frac #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_rrc_frac (
      .clock    (clock),
      .reset    (reset),
      .ctl      (frac_ctl),
      .frac_num (frac_num),
      .frac_den (frac_den),
      .status   (frac_status),
      .res_num  (res_num),
      .res_den  (res_den)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rrc_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = rrc_pkg::ST_RED_A;
            end
         end
         rrc_pkg::ST_RED_A: begin
            if (frac_status.done) begin
               state_in = mode_ff ? rrc_pkg::ST_RED_B : rrc_pkg::ST_HOLD;
            end
         end
         rrc_pkg::ST_RED_B: begin
            if (frac_status.done) begin
               state_in = rrc_pkg::ST_HOLD;
            end
         end
         rrc_pkg::ST_HOLD: begin
            if (load_out) begin
               state_in = rrc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rrc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      mode_in    = mode_ff;
      nb_in      = nb_ff;
      db_in      = db_ff;
      an_in      = an_ff;
      ad_in      = ad_ff;
      eq_in      = eq_ff;
      rsp_num_in = rsp_num_ff;
      rsp_den_in = rsp_den_ff;
      rsp_eq_in  = rsp_eq_ff;
      unique case (state_ff)
         rrc_pkg::ST_IDLE: begin
            if (accept) begin
               mode_in = req_tuser;
               nb_in   = req_tdata[2*FW+VALUE_WIDTH-1:2*FW];
               db_in   = req_tdata[3*FW+VALUE_WIDTH-1:3*FW];
               eq_in   = 1'b0;
            end
         end
         rrc_pkg::ST_RED_A: begin
            if (frac_status.done) begin
               an_in = res_num;
               ad_in = res_den;
            end
         end
         rrc_pkg::ST_RED_B: begin
            if (frac_status.done) begin
               eq_in = (an_ff == res_num) && (ad_ff == res_den);
            end
         end
         rrc_pkg::ST_HOLD: begin
            if (load_out) begin
               rsp_num_in = FW'(an_ff);
               rsp_den_in = FW'(ad_ff);
               rsp_eq_in  = eq_ff;
            end
         end
         default: begin
         end
      endcase
      rsp_valid_in = load_out || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rrc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff    <= mode_in;
      nb_ff      <= nb_in;
      db_ff      <= db_in;
      an_ff      <= an_in;
      ad_ff      <= ad_in;
      eq_ff      <= eq_in;
      rsp_num_ff <= rsp_num_in;
      rsp_den_ff <= rsp_den_in;
      rsp_eq_ff  <= rsp_eq_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(rrc_pkg::RSP_DATA_WIDTH - 2*FW - 1){1'b0}},
                        rsp_eq_ff, rsp_den_ff, rsp_num_ff};

endmodule

// ----- rtl/rrc_checker.sv -----
module rrc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [rrc_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata
);

   // A stalled response keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // The block works on one request at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

   // The fill bits above the equal flag are always zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[rrc_pkg::RSP_DATA_WIDTH-1:rrc_pkg::RSP_EQUAL_BIT+1] == '0))
      else $error("response fill bits set");

   // No response is pending right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind rational_reduce_compare rrc_checker u_rrc_checker (.*);
